### rtl/xfcr_pkg.sv
// xfcr_pkg: shared types and constants of the framed command responder
package xfcr_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_DOLLAR       = 8'h24;
	localparam logic [7:0] CH_UNDERSCORE   = 8'h5F;
	localparam logic [7:0] SCAN_LAST_BYTE  = 8'd23;
	localparam logic [7:0] SCAN_REP_RESET  = 8'd10;
	localparam logic [2:0] MIN_POS_BEFORE_SUM = 3'd6;
	localparam logic [2:0] POS_MAX         = 3'd7;

	localparam logic [3:0] ECHO_LAST_IDX = 4'd7;
	localparam logic [3:0] SCAN_LAST_IDX = 4'd10;

	typedef enum logic [1:0] {
		KIND_REPLY    = 2'd0,
		KIND_CSUM_ERR = 2'd1,
		KIND_UNKNOWN  = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		JOB_CSUM_ERR = 2'd0,
		JOB_UNKNOWN  = 2'd1,
		JOB_ECHO     = 2'd2,
		JOB_SCAN     = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] c3;
		logic [7:0] param;
		logic [7:0] rep;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

endpackage

### rtl/xfcr_front.sv
// xfcr_front: frame tracking, checksum test and command classification
module xfcr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [7:0]             rx_byte,
	input  logic                   end_of_frame,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [7:0]             cfg_data,
	output xfcr_pkg::job_push_t    push
);

	logic [2:0] pos_q;
	logic [7:0] xor_q;
	logic       dollar_q;
	logic [7:0] cmd_q [4];
	logic [7:0] param_q;
	logic [7:0] scan_rep_q;

	logic       accept;
	logic       dollar;
	logic       cmd_tail;
	logic       is_rdy, is_con, is_fre, is_dat;
	logic       respond;
	xfcr_pkg::job_kind_t kind;

	assign accept   = in_valid && !in_stall;
	assign dollar   = (pos_q == 3'd0) ? (rx_byte == xfcr_pkg::CH_DOLLAR) : dollar_q;
	assign cmd_tail = (cmd_q[3] == xfcr_pkg::CH_UNDERSCORE);
	assign is_rdy   = cmd_tail && cmd_q[0] == 8'h72 && cmd_q[1] == 8'h64 && cmd_q[2] == 8'h79;
	assign is_con   = cmd_tail && cmd_q[0] == 8'h63 && cmd_q[1] == 8'h6F && cmd_q[2] == 8'h6E;
	assign is_fre   = cmd_tail && cmd_q[0] == 8'h66 && cmd_q[1] == 8'h72 && cmd_q[2] == 8'h65;
	assign is_dat   = cmd_tail && cmd_q[0] == 8'h64 && cmd_q[1] == 8'h61 && cmd_q[2] == 8'h74;

	always_comb begin
		respond = 1'b1;
		kind    = xfcr_pkg::JOB_UNKNOWN;
		priority if (rx_byte != xor_q) begin
			kind = xfcr_pkg::JOB_CSUM_ERR;
		end else if (pos_q < xfcr_pkg::MIN_POS_BEFORE_SUM) begin
			kind = xfcr_pkg::JOB_UNKNOWN;
		end else if (is_rdy || is_con) begin
			kind = xfcr_pkg::JOB_ECHO;
		end else if (is_fre) begin
			kind = xfcr_pkg::JOB_SCAN;
		end else if (is_dat) begin
			respond = 1'b0;
		end else begin
			kind = xfcr_pkg::JOB_UNKNOWN;
		end
	end

	always_comb begin
		push.push      = accept && end_of_frame && dollar && respond;
		push.job.kind  = kind;
		push.job.c1    = cmd_q[0];
		push.job.c2    = cmd_q[1];
		push.job.c3    = cmd_q[2];
		push.job.param = param_q;
		push.job.rep   = (kind == xfcr_pkg::JOB_SCAN && scan_rep_q != 8'd0) ? scan_rep_q : 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_rep_q <= xfcr_pkg::SCAN_REP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scan_rep_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			xor_q    <= 8'd0;
			dollar_q <= 1'b0;
			param_q  <= 8'd0;
			for (int i = 0; i < 4; i++) cmd_q[i] <= 8'd0;
		end else if (accept) begin
			if (end_of_frame) begin
				pos_q    <= 3'd0;
				xor_q    <= 8'd0;
				dollar_q <= 1'b0;
				param_q  <= 8'd0;
				for (int i = 0; i < 4; i++) cmd_q[i] <= 8'd0;
			end else begin
				dollar_q <= dollar;
				xor_q    <= xor_q ^ rx_byte;
				if (pos_q >= 3'd1 && pos_q <= 3'd4) begin
					cmd_q[pos_q[1:0] - 2'd1] <= rx_byte;
				end
				if (pos_q == 3'd5) begin
					param_q <= rx_byte;
				end
				if (pos_q != xfcr_pkg::POS_MAX) begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

endmodule

### rtl/xfcr_queue.sv
// xfcr_queue: short job queue between front and back
module xfcr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  xfcr_pkg::job_push_t     push,
	input  logic                    pop,
	output xfcr_pkg::queue_status_t status,
	output xfcr_pkg::job_t          head
);

	xfcr_pkg::job_t              mem_q [xfcr_pkg::QUEUE_DEPTH];
	logic [xfcr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [xfcr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [xfcr_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	function automatic logic [xfcr_pkg::QPTR_W-1:0] next_ptr(
		input logic [xfcr_pkg::QPTR_W-1:0] p
	);
		next_ptr = (p == xfcr_pkg::QPTR_W'(xfcr_pkg::QUEUE_DEPTH - 1)) ?
			'0 : p + xfcr_pkg::QPTR_W'(1);
	endfunction

	assign status.full  = (count_q == xfcr_pkg::QCNT_W'(xfcr_pkg::QUEUE_DEPTH));
	assign status.valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];
	assign do_push      = push.push && !status.full;
	assign do_pop       = pop && status.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + xfcr_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - xfcr_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !status.full)
		else $error("job pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.valid)
		else $error("job popped from empty queue");

endmodule

### rtl/xfcr_back.sv
// xfcr_back: turns queued jobs into status items and reply byte runs
module xfcr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  xfcr_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     result_kind,
	output logic [7:0]     reply_byte,
	output logic [7:0]     repeat_total,
	output logic           last_of_run
);

	logic           active_q;
	xfcr_pkg::job_t job_q;
	logic [3:0]     idx_q;
	logic [7:0]     sum_q;

	logic           out_valid_q;
	logic [1:0]     kind_q;
	logic [7:0]     byte_q;
	logic [7:0]     rep_q;
	logic           last_q;

	logic           advance;
	logic           is_last;
	logic [3:0]     last_idx;
	logic [7:0]     frame_byte;
	logic [7:0]     emit_byte;
	logic [1:0]     emit_kind;

	always_comb begin
		unique case (job_q.kind)
			xfcr_pkg::JOB_ECHO: last_idx = xfcr_pkg::ECHO_LAST_IDX;
			xfcr_pkg::JOB_SCAN: last_idx = xfcr_pkg::SCAN_LAST_IDX;
			default:            last_idx = 4'd0;
		endcase
	end

	always_comb begin
		unique case (idx_q)
			4'd0:    frame_byte = xfcr_pkg::CH_DOLLAR;
			4'd1:    frame_byte = job_q.c1;
			4'd2:    frame_byte = job_q.c2;
			4'd3:    frame_byte = job_q.c3;
			4'd4:    frame_byte = xfcr_pkg::CH_UNDERSCORE;
			4'd5:    frame_byte = xfcr_pkg::CH_UNDERSCORE;
			4'd6:    frame_byte = job_q.param;
			4'd9:    frame_byte = xfcr_pkg::SCAN_LAST_BYTE;
			default: frame_byte = 8'd0;
		endcase
	end

	always_comb begin
		unique case (job_q.kind)
			xfcr_pkg::JOB_CSUM_ERR: emit_kind = xfcr_pkg::KIND_CSUM_ERR;
			xfcr_pkg::JOB_UNKNOWN:  emit_kind = xfcr_pkg::KIND_UNKNOWN;
			default:                emit_kind = xfcr_pkg::KIND_REPLY;
		endcase
	end

	assign advance   = active_q && (!out_valid_q || !out_stall);
	assign is_last   = (idx_q == last_idx);
	assign emit_byte = (emit_kind != xfcr_pkg::KIND_REPLY) ? 8'd0 :
		(is_last ? sum_q : frame_byte);
	assign pop       = job_valid && (!active_q || (advance && is_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (advance) begin
			kind_q <= emit_kind;
			byte_q <= emit_byte;
			rep_q  <= job_q.rep;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= 4'd0;
			sum_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= 4'd0;
				sum_q    <= 8'd0;
			end else if (advance) begin
				if (is_last) begin
					active_q <= 1'b0;
				end
				idx_q <= idx_q + 4'd1;
				sum_q <= sum_q ^ frame_byte;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign reply_byte   = byte_q;
	assign repeat_total = rep_q;
	assign last_of_run  = last_q;

	a_status_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != xfcr_pkg::KIND_REPLY |-> last_of_run)
		else $error("status item not marked last of run");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> idx_q <= last_idx)
		else $error("reply index past end of frame");

	a_pop_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop && active_q |-> advance && is_last)
		else $error("job taken while previous run unfinished");

endmodule

### rtl/xor_framed_command_responder.sv
// xor_framed_command_responder: top level of the framed command responder
//
//  channel  signals                                        dir
//  in       in_valid, in_stall, rx_byte, end_of_frame      receive
//  out      out_valid, out_stall, result_kind, reply_byte,
//           repeat_total, last_of_run                      send
//  cfg      cfg_valid, cfg_ready, cfg_data                 receive
//
// one input byte per cycle while in_stall is low; the running xor and byte capture sit in the front
// a frame end queues at most one job; the back sends one result item a cycle
// while out_stall is low, so a reply run holds 8 or 11 items and a status item one
// in_stall rises only while the two-entry job queue is full
// reset clears frame state, queue, output valid and sets the repeat count to 10
module xor_framed_command_responder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [7:0] reply_byte,
	output logic [7:0] repeat_total,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	xfcr_pkg::job_push_t     push;
	xfcr_pkg::queue_status_t q_status;
	xfcr_pkg::job_t          q_head;
	logic                    q_pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_status.full;

	xfcr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.end_of_frame (end_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push)
	);

	xfcr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.status (q_status),
		.head   (q_head)
	);

	xfcr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_status.valid),
		.job          (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.reply_byte   (reply_byte),
		.repeat_total (repeat_total),
		.last_of_run  (last_of_run)
	);

endmodule
